[design/latency_compensated_dry_wet_mixer_core_macros.svh]
// Assertion macros shared by the mixer RTL; ASSERT_OFF compiles them away.
`ifndef LATENCY_COMPENSATED_DRY_WET_MIXER_CORE_MACROS_SVH
`define LATENCY_COMPENSATED_DRY_WET_MIXER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk and disabled while rst is high.
`define LCDWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcdwm assertion failed");
// Next-cycle implication, sampled on clk and disabled while rst is high.
`define LCDWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcdwm assertion failed");
`else
`define LCDWM_ASSERT_IMP(lbl, ante, cons)
`define LCDWM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/lcdwm_pkg.sv]
// Types and constants shared by the dry/wet mixer modules.
package lcdwm_pkg;

  localparam int GAIN_W     = 18;               // Q4.14 gain
  localparam int FRAMES_W   = 12;
  localparam int DLEN_W     = 13;
  localparam int FRAC_EXTRA = 12;               // Q4.14 -> Q4.26
  localparam int CUR_W      = GAIN_W + FRAC_EXTRA;
  localparam int STEP_W     = CUR_W + 1;
  localparam int CNT_W      = 5;                // holds CUR_W divider steps
  localparam int MIX_SHIFT  = 14;
  localparam int ROUND_HALF = 8192;
  localparam int NUM_GAINS  = 4;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 5;

  localparam logic [GAIN_W-1:0]   GAIN_RESET [NUM_GAINS] =
    '{18'd16384, 18'd16384, 18'd0, 18'd0};
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 12'd240;
  localparam logic [DLEN_W-1:0]   DLEN_RESET   = 13'd0;

  typedef enum logic [2:0] {
    REG_WET_LEFT  = 3'd0,
    REG_WET_RIGHT = 3'd1,
    REG_DRY_LEFT  = 3'd2,
    REG_DRY_RIGHT = 3'd3,
    REG_RAMP      = 3'd4,
    REG_DELAY     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAMP,
    ST_MUL,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic start;    // latch a new target and divide out the step
    logic advance;  // apply one ramp step
    logic land;     // final step: take the exact target
  } gain_ctl_t;

  typedef struct packed {
    logic take;     // frame transfer: latch samples and access the delay line
    logic mem_wr;   // write the dry sample into the delay line
    logic bypass;   // zero delay length: use the current dry sample
    logic read_ok;  // the slot read has been written since reset
    logic mul_en;   // register the two products
  } mix_ctl_t;

endpackage

[design/lcdwm_gain_lane.sv]
// One gain lane: ramp state for a single gain with a shift-subtract step divider.
module lcdwm_gain_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  lcdwm_pkg::gain_ctl_t                ctl,
  input  logic [lcdwm_pkg::GAIN_W-1:0]        target,
  input  logic [lcdwm_pkg::FRAMES_W-1:0]      frames,
  input  logic [lcdwm_pkg::GAIN_W-1:0]        reset_gain,
  output logic [lcdwm_pkg::GAIN_W-1:0]        gain14,
  output logic                                busy
);

  logic        [lcdwm_pkg::CUR_W-1:0]    current;
  logic signed [lcdwm_pkg::STEP_W-1:0]   step;
  logic        [lcdwm_pkg::CUR_W-1:0]    quo;
  logic        [lcdwm_pkg::FRAMES_W-1:0] rem;
  logic        [lcdwm_pkg::CNT_W-1:0]    count;
  logic                                  neg;

  logic signed [lcdwm_pkg::STEP_W-1:0]   diff;
  logic signed [lcdwm_pkg::STEP_W-1:0]   diff_abs;
  logic        [lcdwm_pkg::FRAMES_W:0]   rem_sh;
  logic                                  fits;
  logic        [lcdwm_pkg::FRAMES_W:0]   rem_sub;
  logic        [lcdwm_pkg::CUR_W-1:0]    quo_next;
  logic signed [lcdwm_pkg::STEP_W-1:0]   q_signed;
  logic signed [lcdwm_pkg::STEP_W-1:0]   cur_sum;

  assign diff     = $signed({1'b0, target, {lcdwm_pkg::FRAC_EXTRA{1'b0}}})
                  - $signed({1'b0, current});
  assign diff_abs = diff[lcdwm_pkg::STEP_W-1] ? -diff : diff;

  // The remainder stays below the frame count, so one extra bit covers the shift.
  assign rem_sh   = {rem, quo[lcdwm_pkg::CUR_W-1]};
  assign fits     = rem_sh >= {1'b0, frames};
  assign rem_sub  = rem_sh - {1'b0, frames};
  assign quo_next = {quo[lcdwm_pkg::CUR_W-2:0], fits};
  assign q_signed = $signed({1'b0, quo_next});
  assign cur_sum  = $signed({1'b0, current}) + step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      count   <= '0;
      step    <= '0;
      current <= {reset_gain, {lcdwm_pkg::FRAC_EXTRA{1'b0}}};
    end else begin
      if (ctl.start) begin
        quo   <= diff_abs[lcdwm_pkg::CUR_W-1:0];
        rem   <= '0;
        neg   <= diff[lcdwm_pkg::STEP_W-1];
        count <= lcdwm_pkg::CNT_W'(lcdwm_pkg::CUR_W);
        busy  <= 1'b1;
      end else if (busy) begin
        quo   <= quo_next;
        rem   <= fits ? rem_sub[lcdwm_pkg::FRAMES_W-1:0] : rem_sh[lcdwm_pkg::FRAMES_W-1:0];
        count <= count - lcdwm_pkg::CNT_W'(1);
        if (count == lcdwm_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          step <= neg ? -q_signed : q_signed;
        end
      end
      if (ctl.advance) begin
        current <= ctl.land ? {target, {lcdwm_pkg::FRAC_EXTRA{1'b0}}}
                            : cur_sum[lcdwm_pkg::CUR_W-1:0];
      end
    end
  end

  assign gain14 = current[lcdwm_pkg::CUR_W-1:lcdwm_pkg::FRAC_EXTRA];

endmodule

[design/lcdwm_mix_lane.sv]
// One channel lane: dry delay line, two gain products, rounding and saturation.
module lcdwm_mix_lane #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int SB    = 16
) (
  input  logic                          clk,
  input  lcdwm_pkg::mix_ctl_t           ctl,
  input  logic [AW-1:0]                 addr,
  input  logic signed [SB-1:0]          dry,
  input  logic signed [SB-1:0]          wet,
  input  logic [lcdwm_pkg::GAIN_W-1:0]  wet_gain,
  input  logic [lcdwm_pkg::GAIN_W-1:0]  dry_gain,
  output logic signed [SB-1:0]          mixed
);

  localparam int PW = SB + lcdwm_pkg::GAIN_W + 1;
  localparam int SW = PW + 1;
  localparam int QW = SW - lcdwm_pkg::MIX_SHIFT;

  logic signed [SB-1:0] mem [DEPTH];
  logic signed [SB-1:0] dry_q;
  logic signed [SB-1:0] wet_q;
  logic signed [SB-1:0] rd_q;
  logic signed [PW-1:0] prod_w;
  logic signed [PW-1:0] prod_d;

  logic signed [SB-1:0] delayed;
  logic        [SW-1:0] acc;
  logic        [QW-1:0] q;
  logic [QW-SB:0]       q_top;
  logic                 in_range;

  // Read-before-write: the slot returns the sample stored one lap ago.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      dry_q <= dry;
      wet_q <= wet;
      rd_q  <= mem[addr];
      if (ctl.mem_wr) begin
        mem[addr] <= dry;
      end
    end
  end

  assign delayed = ctl.bypass ? dry_q : (ctl.read_ok ? rd_q : '0);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_w <= $signed({1'b0, wet_gain}) * wet_q;
      prod_d <= $signed({1'b0, dry_gain}) * delayed;
    end
  end

  // Round half up, then clamp when the sign bit and the bits above it are not all equal.
  assign acc      = {prod_w[PW-1], prod_w} + {prod_d[PW-1], prod_d}
                  + SW'(lcdwm_pkg::ROUND_HALF);
  assign q        = acc[SW-1:lcdwm_pkg::MIX_SHIFT];
  assign q_top    = q[QW-1:SB-1];
  assign in_range = (&q_top) || !(|q_top);
  assign mixed    = in_range ? $signed(q[SB-1:0])
                  : (q[QW-1] ? $signed({1'b1, {(SB-1){1'b0}}})
                             : $signed({1'b0, {(SB-1){1'b1}}}));

endmodule

[design/latency_compensated_dry_wet_mixer_core.sv]
// Top level of the latency-compensated stereo dry/wet mixer with gain ramping.
//
// Usage: one stereo frame (dry and wet sample per channel) is taken per input
// transfer on in_valid/in_stall; one mixed frame plus the ramp_busy flag leaves
// per output transfer on out_valid/out_stall. Gains and delay are set through
// the APB port; the user must write them only while no frame is in flight,
// as the block itself does not enforce it. After its transfer a frame passes
// the ramp step, the products and the sum and clamp before its result is
// loaded into the output register. A frame that finds new target gains first
// waits for the bit-per-cycle step dividers in the four gain lanes. At most
// one frame is inside the block; the next input transfer is taken as soon as
// the previous result sits in the output register, even while that result
// still waits.
// When the receiver stalls, the result holds in the output register and a
// further finished result waits in the sum stage, so input stops after one.
// Reset (synchronous, rst high) sets the registers to their defaults, the gains
// to their targets and the delay position to zero. The delay line needs no
// clearing pass: a fill count marks the written slots and unwritten ones read
// as zero.
`include "latency_compensated_dry_wet_mixer_core_macros.svh"

module latency_compensated_dry_wet_mixer_core #(
  parameter int DELAY_DEPTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lcdwm_pkg::APB_AW-1:0]       paddr,
  input  logic [lcdwm_pkg::APB_DW-1:0]       pwdata,
  output logic [lcdwm_pkg::APB_DW-1:0]       prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      dry_left,
  input  logic signed [SAMPLE_BITS-1:0]      dry_right,
  input  logic signed [SAMPLE_BITS-1:0]      wet_left,
  input  logic signed [SAMPLE_BITS-1:0]      wet_right,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      mixed_left,
  output logic signed [SAMPLE_BITS-1:0]      mixed_right,
  output logic                               ramp_busy
);

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW = $clog2(DELAY_DEPTH + 1);

  // Configuration registers.
  logic [lcdwm_pkg::GAIN_W-1:0]   gain_cfg [lcdwm_pkg::NUM_GAINS];
  logic [lcdwm_pkg::FRAMES_W-1:0] ramp_frames;
  logic [lcdwm_pkg::DLEN_W-1:0]   delay_length;

  // Block state.
  lcdwm_pkg::state_t              state;
  lcdwm_pkg::state_t              state_next;
  logic [lcdwm_pkg::GAIN_W-1:0]   last_targets [lcdwm_pkg::NUM_GAINS];
  logic [lcdwm_pkg::FRAMES_W-1:0] ramp_left;
  logic [AW-1:0]                  pos;
  logic [CW-1:0]                  fill;
  logic                           bypass;
  logic                           read_ok;

  logic                           cfg_wr;
  lcdwm_pkg::reg_idx_t            cfg_idx;
  logic                           accept;
  logic                           changed;
  logic [lcdwm_pkg::FRAMES_W-1:0] frames_eff;
  logic [31:0]                    len32;
  logic [CW-1:0]                  len;
  logic                           len_zero;
  logic [AW-1:0]                  pos_fix;
  logic [CW-1:0]                  pos_inc;
  logic                           any_busy;
  logic                           advance;
  logic                           mul_en;
  logic                           load_out;

  lcdwm_pkg::gain_ctl_t           gctl;
  lcdwm_pkg::mix_ctl_t            mctl;
  logic [lcdwm_pkg::GAIN_W-1:0]   gain14 [lcdwm_pkg::NUM_GAINS];
  logic [lcdwm_pkg::NUM_GAINS-1:0] lane_busy;
  logic signed [SAMPLE_BITS-1:0]  mix_l;
  logic signed [SAMPLE_BITS-1:0]  mix_r;

  // ---------------------------------------------------------------- APB port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = lcdwm_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < lcdwm_pkg::NUM_GAINS; k++) begin
        gain_cfg[k] <= lcdwm_pkg::GAIN_RESET[k];
      end
      ramp_frames  <= lcdwm_pkg::FRAMES_RESET;
      delay_length <= lcdwm_pkg::DLEN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lcdwm_pkg::REG_WET_LEFT:  gain_cfg[0]  <= pwdata[lcdwm_pkg::GAIN_W-1:0];
        lcdwm_pkg::REG_WET_RIGHT: gain_cfg[1]  <= pwdata[lcdwm_pkg::GAIN_W-1:0];
        lcdwm_pkg::REG_DRY_LEFT:  gain_cfg[2]  <= pwdata[lcdwm_pkg::GAIN_W-1:0];
        lcdwm_pkg::REG_DRY_RIGHT: gain_cfg[3]  <= pwdata[lcdwm_pkg::GAIN_W-1:0];
        lcdwm_pkg::REG_RAMP:      ramp_frames  <= pwdata[lcdwm_pkg::FRAMES_W-1:0];
        lcdwm_pkg::REG_DELAY:     delay_length <= pwdata[lcdwm_pkg::DLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      lcdwm_pkg::REG_WET_LEFT:  prdata = lcdwm_pkg::APB_DW'(gain_cfg[0]);
      lcdwm_pkg::REG_WET_RIGHT: prdata = lcdwm_pkg::APB_DW'(gain_cfg[1]);
      lcdwm_pkg::REG_DRY_LEFT:  prdata = lcdwm_pkg::APB_DW'(gain_cfg[2]);
      lcdwm_pkg::REG_DRY_RIGHT: prdata = lcdwm_pkg::APB_DW'(gain_cfg[3]);
      lcdwm_pkg::REG_RAMP:      prdata = lcdwm_pkg::APB_DW'(ramp_frames);
      lcdwm_pkg::REG_DELAY:     prdata = lcdwm_pkg::APB_DW'(delay_length);
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------- frame bookkeeping
  always_comb begin
    changed = 1'b0;
    for (int k = 0; k < lcdwm_pkg::NUM_GAINS; k++) begin
      if (gain_cfg[k] != last_targets[k]) begin
        changed = 1'b1;
      end
    end
  end

  assign frames_eff = (ramp_frames == '0) ? lcdwm_pkg::FRAMES_W'(1) : ramp_frames;

  // Lengths beyond the store clamp to its depth.
  assign len32    = (32'(delay_length) > 32'(DELAY_DEPTH)) ? 32'(DELAY_DEPTH)
                                                           : 32'(delay_length);
  assign len      = len32[CW-1:0];
  assign len_zero = (len == '0);
  assign pos_fix  = (len_zero || (CW'(pos) >= len)) ? '0 : pos;
  assign pos_inc  = CW'(pos_fix) + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      fill      <= '0;
      ramp_left <= '0;
      for (int k = 0; k < lcdwm_pkg::NUM_GAINS; k++) begin
        last_targets[k] <= lcdwm_pkg::GAIN_RESET[k];
      end
    end else begin
      if (accept) begin
        bypass  <= len_zero;
        read_ok <= CW'(pos_fix) < fill;
        if (len_zero) begin
          pos <= '0;
        end else begin
          pos <= (pos_inc >= len) ? '0 : pos_inc[AW-1:0];
          if (pos_inc > fill) begin
            fill <= pos_inc;
          end
        end
        if (changed) begin
          ramp_left <= frames_eff;
          for (int k = 0; k < lcdwm_pkg::NUM_GAINS; k++) begin
            last_targets[k] <= gain_cfg[k];
          end
        end
      end else if (advance) begin
        ramp_left <= ramp_left - lcdwm_pkg::FRAMES_W'(1);
      end
    end
  end

  // ------------------------------------------------------------ control FSM
  assign any_busy = |lane_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdwm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lcdwm_pkg::ST_IDLE: if (in_valid) state_next = lcdwm_pkg::ST_RAMP;
      lcdwm_pkg::ST_RAMP: if (!any_busy) state_next = lcdwm_pkg::ST_MUL;
      lcdwm_pkg::ST_MUL:  state_next = lcdwm_pkg::ST_SUM;
      lcdwm_pkg::ST_SUM:  if (!out_valid || !out_stall) state_next = lcdwm_pkg::ST_IDLE;
      default:            state_next = lcdwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    advance  = 1'b0;
    mul_en   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      lcdwm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      lcdwm_pkg::ST_RAMP: advance  = !any_busy && (ramp_left != '0);
      lcdwm_pkg::ST_MUL:  mul_en   = 1'b1;
      lcdwm_pkg::ST_SUM:  load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // ------------------------------------------------------------------ lanes
  assign gctl.start   = accept && changed;
  assign gctl.advance = advance;
  assign gctl.land    = (ramp_left == lcdwm_pkg::FRAMES_W'(1));

  for (genvar g = 0; g < lcdwm_pkg::NUM_GAINS; g++) begin : g_gain
    lcdwm_gain_lane u_gain (
      .clk        (clk),
      .rst        (rst),
      .ctl        (gctl),
      .target     (gain_cfg[g]),
      .frames     (frames_eff),
      .reset_gain (lcdwm_pkg::GAIN_RESET[g]),
      .gain14     (gain14[g]),
      .busy       (lane_busy[g])
    );
  end

  assign mctl.take    = accept;
  assign mctl.mem_wr  = accept && !len_zero;
  assign mctl.bypass  = bypass;
  assign mctl.read_ok = read_ok;
  assign mctl.mul_en  = mul_en;

  lcdwm_mix_lane #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW),
    .SB    (SAMPLE_BITS)
  ) u_mix_left (
    .clk      (clk),
    .ctl      (mctl),
    .addr     (pos_fix),
    .dry      (dry_left),
    .wet      (wet_left),
    .wet_gain (gain14[0]),
    .dry_gain (gain14[2]),
    .mixed    (mix_l)
  );

  lcdwm_mix_lane #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW),
    .SB    (SAMPLE_BITS)
  ) u_mix_right (
    .clk      (clk),
    .ctl      (mctl),
    .addr     (pos_fix),
    .dry      (dry_right),
    .wet      (wet_right),
    .wet_gain (gain14[1]),
    .dry_gain (gain14[3]),
    .mixed    (mix_r)
  );

  // ---------------------------------------------------- merge and output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mixed_left  <= mix_l;
      mixed_right <= mix_r;
      ramp_busy   <= (ramp_left != '0);
    end
  end

  // ------------------------------------------------------------- assertions
  `LCDWM_ASSERT_NXT(a_accept_to_ramp, accept, state == lcdwm_pkg::ST_RAMP)
  `LCDWM_ASSERT_IMP(a_div_only_in_ramp, any_busy, state == lcdwm_pkg::ST_RAMP)
  `LCDWM_ASSERT_IMP(a_pos_within_fill, 1'b1, CW'(pos) <= fill)
  `LCDWM_ASSERT_IMP(a_out_from_sum, $rose(out_valid), $past(state) == lcdwm_pkg::ST_SUM)
  `LCDWM_ASSERT_IMP(a_fill_bounded, 1'b1, 32'(fill) <= 32'(DELAY_DEPTH))

endmodule
